// ----- rtl/fpa_pkg.sv -----
`default_nettype none
package fpa_pkg;
    localparam int unsigned FracBitsDefault = 8;
    localparam int unsigned WordW = 32;
    localparam int unsigned KindW = 4;

    typedef enum logic [KindW-1:0] {
        K_ADD = 4'd0, K_SUB = 4'd1, K_MUL = 4'd2, K_DIV = 4'd3,
        K_GT = 4'd4, K_LT = 4'd5, K_GE = 4'd6, K_LE = 4'd7,
        K_EQ = 4'd8, K_NE = 4'd9, K_MIN = 4'd10, K_MAX = 4'd11,
        K_INC = 4'd12, K_DEC = 4'd13, K_TOINT = 4'd14, K_FROMINT = 4'd15
    } t_kind;

    // Word handed from cell to cell of the divider chain.
    typedef struct packed {
        logic             vld;
        logic             div;     // item is a divide that still needs its quotient
        logic             neg;     // quotient sign
        logic [63:0]      rem;     // partial remainder
        logic [63:0]      num;     // dividend bits still to shift in, msb first
        logic [WordW-1:0] den;     // divisor magnitude
        logic [63:0]      quo;
        logic [WordW-1:0] res;     // finished result for non-divide items
        logic             flag;
    } t_cell;
endpackage
`default_nettype wire

// ----- rtl/fpa_cell.sv -----
`default_nettype none
// STEPS restoring-division steps per cell; all other items pass through.
module fpa_cell #(
    parameter int unsigned STEPS = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  fpa_pkg::t_cell  i_cell,
    output fpa_pkg::t_cell  o_cell
);
    fpa_pkg::t_cell r_cell, n_cell;
    logic [64:0] trial;

    always_comb begin
        n_cell = i_cell;
        trial  = '0;
        if (i_cell.div) begin
            for (int s = 0; s < STEPS; s++) begin
                trial = {n_cell.rem, n_cell.num[63]} - {33'd0, n_cell.den};
                n_cell.num = {n_cell.num[62:0], 1'b0};
                if (!trial[64]) begin
                    n_cell.rem = trial[63:0];
                    n_cell.quo = {n_cell.quo[62:0], 1'b1};
                end else begin
                    n_cell.rem = {n_cell.rem[62:0], i_cell.num[63-s]};
                    n_cell.quo = {n_cell.quo[62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= n_cell.vld;
        end
        if (i_en) begin
            r_cell.div  <= n_cell.div;
            r_cell.neg  <= n_cell.neg;
            r_cell.rem  <= n_cell.rem;
            r_cell.num  <= n_cell.num;
            r_cell.den  <= n_cell.den;
            r_cell.quo  <= n_cell.quo;
            r_cell.res  <= n_cell.res;
            r_cell.flag <= n_cell.flag;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

// ----- rtl/fixed_point_alu.sv -----
`default_nettype none
// Q-format fixed-point ALU on signed 32-bit words with FRAC_BITS fraction bits.
// Input channel s_axis: tdata = {operand_b, operand_a} (a in bits 31:0),
// tuser = kind (0 add .. 15 from_int). Output channel m_axis: tdata =
// result_word, tuser = flag (compare outcome or divide-by-zero mark).
// Every item goes through one input stage, a chain of 32 division cells
// (two quotient bits each, 64 bits total) and an output stage, and results
// leave in order. Throughput is one item per cycle while the receiver takes
// results: the whole chain advances together.
// The multiply is done in the input stage as one 32x32 product.
// When the receiver stalls with a result waiting, the whole chain holds;
// tready falls only then, so a stalled output never loses a word.
// Synchronous active-low reset empties the chain; payload is not cleared.
module fixed_point_alu #(
    parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    input  wire logic [3:0]  s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // result_word
    output logic             m_axis_tuser    // flag
);
    localparam int unsigned NCells = 32;

    logic signed [31:0] a, b;
    logic [3:0]         kind;
    fpa_pkg::t_cell     in_cell;
    fpa_pkg::t_cell     chain [NCells+1];
    logic               en;
    logic signed [63:0] prod;
    logic [31:0]        mag_a, mag_b, tq;
    logic [31:0]        r_res;
    logic               r_flag, r_vld;
    logic [31:0]        n_res;

    assign a    = s_axis_tdata[31:0];
    assign b    = s_axis_tdata[63:32];
    assign kind = s_axis_tuser;

    // Advance unless a finished word sits unclaimed at the output.
    assign en            = !r_vld || m_axis_tready;
    assign s_axis_tready = en;

    assign prod  = 64'(a) * 64'(b);
    assign mag_a = a[31] ? 32'(-a) : a;
    assign mag_b = b[31] ? 32'(-b) : b;
    assign tq    = mag_a >> FRAC_BITS;

    always_comb begin
        in_cell      = '0;
        in_cell.vld  = s_axis_tvalid;
        in_cell.num  = {32'd0, mag_a} << FRAC_BITS;
        in_cell.den  = mag_b;
        in_cell.neg  = a[31] ^ b[31];
        unique case (fpa_pkg::t_kind'(kind))
            fpa_pkg::K_ADD:     in_cell.res = a + b;
            fpa_pkg::K_SUB:     in_cell.res = a - b;
            fpa_pkg::K_MUL:     in_cell.res = prod[FRAC_BITS +: 32];
            fpa_pkg::K_DIV: begin
                in_cell.flag = (b == 0);
                in_cell.div  = (b != 0);
            end
            fpa_pkg::K_GT:      in_cell.flag = a > b;
            fpa_pkg::K_LT:      in_cell.flag = a < b;
            fpa_pkg::K_GE:      in_cell.flag = !(a < b);
            fpa_pkg::K_LE:      in_cell.flag = !(a > b);
            fpa_pkg::K_EQ:      in_cell.flag = a == b;
            fpa_pkg::K_NE:      in_cell.flag = a != b;
            fpa_pkg::K_MIN:     in_cell.res = (a < b) ? a : b;
            fpa_pkg::K_MAX:     in_cell.res = (a > b) ? a : b;
            fpa_pkg::K_INC:     in_cell.res = a + 32'sd1;
            fpa_pkg::K_DEC:     in_cell.res = a - 32'sd1;
            fpa_pkg::K_TOINT:   in_cell.res = a[31] ? 32'(-tq) : tq;
            fpa_pkg::K_FROMINT: in_cell.res = a << FRAC_BITS;
            default:            in_cell.res = '0;
        endcase
    end

    // Input stage register, then the cell chain.
    fpa_pkg::t_cell r_in;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else if (en) begin
            r_in.vld <= in_cell.vld;
        end
        if (en) begin
            r_in.div  <= in_cell.div;
            r_in.neg  <= in_cell.neg;
            r_in.rem  <= in_cell.rem;
            r_in.num  <= in_cell.num;
            r_in.den  <= in_cell.den;
            r_in.quo  <= in_cell.quo;
            r_in.res  <= in_cell.res;
            r_in.flag <= in_cell.flag;
        end
    end
    assign chain[0] = r_in;

    for (genvar g = 0; g < NCells; g++) begin : g_cell
        fpa_cell #(.STEPS(2)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    // Apply quotient sign for divides; other items carry their result.
    always_comb begin
        if (chain[NCells].div) begin
            n_res = chain[NCells].neg ? 32'(-chain[NCells].quo) : chain[NCells].quo[31:0];
        end else begin
            n_res = chain[NCells].res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= chain[NCells].vld;
        end
        if (en) begin
            r_res  <= n_res;
            r_flag <= chain[NCells].flag;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_res;
    assign m_axis_tuser  = r_flag;
endmodule
`default_nettype wire

// ----- bench/fixed_point_alu_test.sv -----
`default_nettype none
module fixed_point_alu_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC = fpa_pkg::FracBitsDefault;
    localparam int ITEMS = 700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    // One expected result word: value and flag.
    typedef struct packed {
        logic [31:0] word;
        logic        flag;
    } t_alu_out;

    // Keep the expected words in order and compare each returned word with the oldest one.
    class alu_scoreboard;
        t_alu_out pending[$];
        int mismatches;

        function automatic t_alu_out compute(fpa_pkg::t_kind op, logic signed [31:0] a,
                                             logic signed [31:0] b);
            t_alu_out r;
            logic signed [63:0] prod;
            logic [63:0] num, q, ma, mb;
            r = '0;
            case (op)
                fpa_pkg::K_ADD: r.word = a + b;
                fpa_pkg::K_SUB: r.word = a - b;
                fpa_pkg::K_MUL: begin
                    prod = 64'(a) * 64'(b);
                    r.word = 32'(prod >>> FRAC);
                end
                fpa_pkg::K_DIV: begin
                    if (b == 0) begin
                        r.flag = 1'b1;
                    end else begin
                        ma = a < 0 ? -64'(a) : 64'(a);
                        mb = b < 0 ? -64'(b) : 64'(b);
                        num = ma << FRAC;
                        q = num / mb;
                        r.word = ((a < 0) != (b < 0)) ? 32'(-q) : 32'(q);
                    end
                end
                fpa_pkg::K_GT: r.flag = a > b;
                fpa_pkg::K_LT: r.flag = a < b;
                fpa_pkg::K_GE: r.flag = !(a < b);
                fpa_pkg::K_LE: r.flag = !(a > b);
                fpa_pkg::K_EQ: r.flag = a == b;
                fpa_pkg::K_NE: r.flag = a != b;
                fpa_pkg::K_MIN: r.word = (a < b) ? a : b;
                fpa_pkg::K_MAX: r.word = (a > b) ? a : b;
                fpa_pkg::K_INC: r.word = a + 1;
                fpa_pkg::K_DEC: r.word = a - 1;
                fpa_pkg::K_TOINT: begin
                    ma = a < 0 ? -64'(a) : 64'(a);
                    q = ma >> FRAC;
                    r.word = a < 0 ? 32'(-q) : 32'(q);
                end
                default: r.word = a << FRAC;
            endcase
            return r;
        endfunction

        function void note_operation(fpa_pkg::t_kind op, logic [31:0] a, logic [31:0] b);
            pending.push_back(compute(op, a, b));
        endfunction

        function void check_result(logic [31:0] word, logic flag);
            t_alu_out e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: result %h flag %b", word, flag);
                return;
            end
            e = pending.pop_front();
            if (e.word !== word || e.flag !== flag) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("bad word: expected %h/%b got %h/%b",
                             e.word, e.flag, word, flag);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // operand_a[31:0], operand_b[63:32]
    logic [3:0]  s_axis_tuser = '0;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // result_word
    logic        m_axis_tuser;        // flag

    alu_scoreboard board = new();
    bit quiet_phase = 1'b0;   // no idling on either side near the end
    bit sending_done = 1'b0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    fixed_point_alu #(.FRAC_BITS(FRAC)) DUT (.*);

    // Note accepted words and check results, both at the sampling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_operation(fpa_pkg::t_kind'(s_axis_tuser), s_axis_tdata[31:0],
                                     s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall in random bursts until the quiet phase.
    initial begin : receiver
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Hold one word on the input until it is taken; idle before it at random.
    task automatic send_word(fpa_pkg::t_kind op, logic [31:0] a, logic [31:0] b);
        int n;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Pick operands that often hit the edges of the word range.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 2)) - 32'd1;
            3: return 32'($urandom_range(0, 4095)) - 32'd2048;
            4: return 32'($urandom_range(0, 1)) << FRAC;
            default: return $urandom;
        endcase
    endfunction

    // Directed: every operation on the field extremes, zero divisors, truncation cases.
    initial begin : stimulus
        logic [31:0] edges[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                  32'hffff_ff80};
        fpa_pkg::t_kind op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < 16; k++)
            send_word(fpa_pkg::t_kind'(k), edges[k % 5], edges[(k + 2) % 5]);
        send_word(fpa_pkg::K_DIV, 32'h0000_0100, 32'h0);
        send_word(fpa_pkg::K_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_word(fpa_pkg::K_DIV, 32'hffff_ff01, 32'h0000_0300);
        send_word(fpa_pkg::K_TOINT, 32'hffff_fe80, 32'h0);
        send_word(fpa_pkg::K_MIN, 32'h1234_5678, 32'h1234_5678);
        send_word(fpa_pkg::K_MAX, 32'h8000_0000, 32'h8000_0000);
        send_word(fpa_pkg::K_MUL, 32'h8000_0000, 32'h8000_0000);
        for (int i = 0; i < ITEMS; i++) begin
            if (i == ITEMS - 120) quiet_phase = 1'b1;
            op = fpa_pkg::t_kind'($urandom_range(0, 15));
            if ($urandom_range(0, 1)) send_word(op, pick_operand(), pick_operand());
            else send_word(op, $urandom, $urandom);
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // Finish when drained, or when nothing moves for too long.
    initial begin : finisher
        @(posedge i_clk iff (sending_done && board.pending.size() == 0)
                   || idle_cycles >= WATCHDOG_LIMIT);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fixed_point_alu: mismatch");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (board.mismatches == 0 && board.pending.size() == 0)
                $display("fixed_point_alu: match");
            else
                $display("fixed_point_alu: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
